// ===== rtl/core/key_value_table_with_rank_query_top_defines.svh =====
// ---------------------------------------------------------------------------
// key value table assertion macros
// concurrent checks on clk_i, disabled while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef KEY_VALUE_TABLE_WITH_RANK_QUERY_TOP_DEFINES_SVH
`define KEY_VALUE_TABLE_WITH_RANK_QUERY_TOP_DEFINES_SVH

`ifndef SYNTH
// plain property
`define KVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// same-cycle implication
`define KVT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define KVT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KVT_ASSERT(lbl, prop, msg)
`define KVT_ASSERT_IMP(lbl, ante, cons, msg)
`define KVT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/kvt_pkg.sv =====
// ---------------------------------------------------------------------------
// key value table package
// field widths, stream packing offsets, operation codes and defaults
// ---------------------------------------------------------------------------
`default_nettype none

package kvt_pkg;

  // item field widths
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned RANK_W      = 5;
  localparam int unsigned COUNT_OUT_W = 6;

  // input tdata layout, lowest field first
  localparam int unsigned IN_MODE_LSB  = 0;
  localparam int unsigned IN_KEY_LSB   = IN_MODE_LSB + MODE_W;
  localparam int unsigned IN_VALUE_LSB = IN_KEY_LSB + KEY_W;
  localparam int unsigned IN_RANK_LSB  = IN_VALUE_LSB + VALUE_W;
  localparam int unsigned IN_BITS      = IN_RANK_LSB + RANK_W;
  localparam int unsigned IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

  // output tdata layout, lowest field first
  localparam int unsigned OUT_BITS    = 1 + KEY_W + VALUE_W + COUNT_OUT_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

  // parameter defaults
  localparam int unsigned DEF_CAPACITY   = 32;
  localparam int unsigned DEF_KEY_BITS   = 32;
  localparam int unsigned DEF_VALUE_BITS = 32;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 3'd0,
    MODE_UPDATE = 3'd1,
    MODE_UPSERT = 3'd2,
    MODE_ERASE  = 3'd3,
    MODE_LOOKUP = 3'd4,
    MODE_RANK   = 3'd5
  } mode_e;

endpackage

`default_nettype wire

// ===== rtl/core/kvt_ram.sv =====
// ---------------------------------------------------------------------------
// kvt_ram
// simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module kvt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/key_value_table_with_rank_query_top.sv =====
// ---------------------------------------------------------------------------
// key value table with rank query
// fixed-capacity table of unique keys, one value per key, walked by a
// single comparator under a small sequencer
// ---------------------------------------------------------------------------
//
// channel   dir  fields (tdata, lowest bit first)
// s_axis    in   mode[2:0] key[31:0] new_value[31:0] rank[4:0]
// m_axis    out  ok found_key[31:0] found_value[31:0] entry_count[5:0] zero pad
//
// one item at a time, worked on from the accepting edge to the loaded result
// insert, update, insert-or-update: one key scan, then the write, if any
// lookup: one key scan, then a value read on a hit
// erase: one key scan, then on a hit the later entries shift down one slot
// get-by-rank: one full key sweep per candidate
// reset clears the entry count and the other registers, not the rams; a stalled
//   result sits in the output register while the next item is taken and worked on
//
`default_nettype none

`include "key_value_table_with_rank_query_top_defines.svh"

module key_value_table_with_rank_query_top
  import kvt_pkg::*;
#(
  parameter int unsigned CAPACITY   = DEF_CAPACITY,
  parameter int unsigned KEY_BITS   = DEF_KEY_BITS,
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // input items
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // mode, key, new_value, rank
  // result items
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata_o   // ok, found_key, found_value,
                                                       // entry_count, zero pad
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned RKW  = (CW > RANK_W) ? CW : RANK_W;
  // meaningful key and value bits coming in and going out
  localparam int unsigned KIN  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned VIN  = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_ACT,
    ST_SHIFT,
    ST_RK_LOAD,
    ST_RK_CAND,
    ST_RK_SWEEP,
    ST_VAL_RD,
    ST_VAL_CAP,
    ST_OUT
  } state_e;

  state_e                  state_q;
  logic [MODE_W-1:0]       mode_q;
  logic [KEY_BITS-1:0]     key_q;
  logic [VALUE_BITS-1:0]   val_q;
  logic [RANK_W-1:0]       rank_q;
  logic [CW-1:0]           count_q;
  logic [CW-1:0]           idx_q;        // sweep read pointer
  logic                    rd_vld_q;     // ram data of last cycle belongs to the sweep
  logic [AW-1:0]           rd_idx_q;     // entry that data came from
  logic [AW-1:0]           slot_q;       // hit slot, or rank candidate
  logic                    hit_q;
  logic [KEY_BITS-1:0]     cand_q;
  logic [CW-1:0]           smaller_q;
  logic                    res_ok_q;
  logic [KEY_W-1:0]        res_fk_q;
  logic [VALUE_W-1:0]      res_fv_q;
  logic                    out_valid_q;
  logic [OUT_TDATA_W-1:0]  out_data_q;

  // input item fields
  logic [MODE_W-1:0]  in_mode;
  logic [KEY_W-1:0]   in_key;
  logic [VALUE_W-1:0] in_value;
  logic [RANK_W-1:0]  in_rank;
  logic               in_fire;
  logic               out_load;

  assign in_mode  = s_axis_tdata_i[IN_MODE_LSB  +: MODE_W];
  assign in_key   = s_axis_tdata_i[IN_KEY_LSB   +: KEY_W];
  assign in_value = s_axis_tdata_i[IN_VALUE_LSB +: VALUE_W];
  assign in_rank  = s_axis_tdata_i[IN_RANK_LSB  +: RANK_W];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  // load the output register once the previous result has left
  assign out_load        = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready_i);

  // ram ports
  logic                  key_we;
  logic                  val_we;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic [KEY_BITS-1:0]   key_wdata;
  logic [VALUE_BITS-1:0] val_wdata;
  logic [KEY_BITS-1:0]   key_rdata;
  logic [VALUE_BITS-1:0] val_rdata;

  kvt_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (wr_addr),
    .wdata_i (key_wdata),
    .raddr_i (rd_addr),
    .rdata_o (key_rdata)
  );

  kvt_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (wr_addr),
    .wdata_i (val_wdata),
    .raddr_i (rd_addr),
    .rdata_o (val_rdata)
  );

  // the one shared comparator: sweep data against the search key or the candidate
  logic [KEY_BITS-1:0] cmp_ref;
  logic                key_eq;
  logic                key_lt;

  assign cmp_ref = (state_q == ST_RK_SWEEP) ? cand_q : key_q;
  assign key_eq  = (key_rdata == cmp_ref);
  assign key_lt  = (key_rdata < cmp_ref);

  logic          is_insert_mode;
  logic          is_update_mode;
  logic          not_full;
  logic          act_append;
  logic          act_update;
  logic          sweep_end;
  logic [CW-1:0] smaller_next;

  assign is_insert_mode = (mode_q == MODE_INSERT) || (mode_q == MODE_UPSERT);
  assign is_update_mode = (mode_q == MODE_UPDATE) || (mode_q == MODE_UPSERT);
  assign not_full       = (count_q < CW'(CAPACITY));
  assign act_append     = (state_q == ST_ACT) && !hit_q && is_insert_mode && not_full;
  assign act_update     = (state_q == ST_ACT) && hit_q && is_update_mode;
  assign sweep_end      = (idx_q == count_q);
  assign smaller_next   = smaller_q + CW'(rd_vld_q && key_lt);

  always_comb begin
    key_we    = 1'b0;
    val_we    = 1'b0;
    wr_addr   = count_q[AW-1:0];
    key_wdata = key_q;
    val_wdata = val_q;
    rd_addr   = idx_q[AW-1:0];
    unique case (state_q)
      ST_ACT: begin
        if (act_append) begin
          key_we = 1'b1;
          val_we = 1'b1;
        end else if (act_update) begin
          val_we  = 1'b1;
          wr_addr = slot_q;
        end
      end
      ST_SHIFT: begin
        // move the entry read last cycle one slot down
        key_we    = rd_vld_q;
        val_we    = rd_vld_q;
        wr_addr   = rd_idx_q - AW'(1);
        key_wdata = key_rdata;
        val_wdata = val_rdata;
      end
      ST_RK_LOAD, ST_VAL_RD: begin
        rd_addr = slot_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= '0;
      key_q       <= '0;
      val_q       <= '0;
      rank_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      slot_q      <= '0;
      hit_q       <= 1'b0;
      cand_q      <= '0;
      smaller_q   <= '0;
      res_ok_q    <= 1'b0;
      res_fk_q    <= '0;
      res_fv_q    <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            mode_q    <= in_mode;
            key_q     <= KEY_BITS'(in_key[KIN-1:0]);
            val_q     <= VALUE_BITS'(in_value[VIN-1:0]);
            rank_q    <= in_rank;
            res_ok_q  <= 1'b0;
            res_fk_q  <= '0;
            res_fv_q  <= '0;
            idx_q     <= '0;
            rd_vld_q  <= 1'b0;
            hit_q     <= 1'b0;
            slot_q    <= '0;
            priority if (in_mode == MODE_RANK) begin
              if (RKW'(in_rank) < RKW'(count_q)) begin
                state_q <= ST_RK_LOAD;
              end else begin
                state_q <= ST_OUT;
              end
            end else if (in_mode <= MODE_LOOKUP) begin
              state_q <= ST_FIND;
            end else begin
              // unused codes: no operation
              state_q <= ST_OUT;
            end
          end
        end

        ST_FIND: begin
          if (rd_vld_q && key_eq) begin
            hit_q    <= 1'b1;
            slot_q   <= rd_idx_q;
            rd_vld_q <= 1'b0;
            state_q  <= ST_ACT;
          end else if (sweep_end) begin
            rd_vld_q <= 1'b0;
            state_q  <= ST_ACT;
          end else begin
            rd_vld_q <= 1'b1;
            rd_idx_q <= idx_q[AW-1:0];
            idx_q    <= idx_q + CW'(1);
          end
        end

        ST_ACT: begin
          state_q <= ST_OUT;
          unique case (mode_q)
            MODE_INSERT, MODE_UPSERT: begin
              if (act_append) begin
                count_q  <= count_q + CW'(1);
                res_ok_q <= 1'b1;
              end else begin
                res_ok_q <= act_update;
              end
            end
            MODE_UPDATE: begin
              res_ok_q <= hit_q;
            end
            MODE_ERASE: begin
              if (hit_q) begin
                idx_q    <= CW'(slot_q) + CW'(1);
                rd_vld_q <= 1'b0;
                state_q  <= ST_SHIFT;
              end
            end
            MODE_LOOKUP: begin
              if (hit_q) begin
                state_q <= ST_VAL_RD;
              end
            end
            default: begin
              res_ok_q <= 1'b0;
            end
          endcase
        end

        ST_SHIFT: begin
          if (sweep_end) begin
            count_q  <= count_q - CW'(1);
            res_ok_q <= 1'b1;
            rd_vld_q <= 1'b0;
            state_q  <= ST_OUT;
          end else begin
            rd_vld_q <= 1'b1;
            rd_idx_q <= idx_q[AW-1:0];
            idx_q    <= idx_q + CW'(1);
          end
        end

        ST_RK_LOAD: begin
          state_q <= ST_RK_CAND;
        end

        ST_RK_CAND: begin
          cand_q    <= key_rdata;
          idx_q     <= '0;
          smaller_q <= '0;
          rd_vld_q  <= 1'b0;
          state_q   <= ST_RK_SWEEP;
        end

        ST_RK_SWEEP: begin
          if (sweep_end) begin
            rd_vld_q <= 1'b0;
            if (RKW'(smaller_next) == RKW'(rank_q)) begin
              res_fk_q <= KEY_W'(cand_q[KIN-1:0]);
              state_q  <= ST_VAL_RD;
            end else begin
              slot_q  <= slot_q + AW'(1);
              state_q <= ST_RK_LOAD;
            end
          end else begin
            smaller_q <= smaller_next;
            rd_vld_q  <= 1'b1;
            rd_idx_q  <= idx_q[AW-1:0];
            idx_q     <= idx_q + CW'(1);
          end
        end

        ST_VAL_RD: begin
          state_q <= ST_VAL_CAP;
        end

        ST_VAL_CAP: begin
          res_fv_q <= VALUE_W'(val_rdata[VIN-1:0]);
          res_ok_q <= 1'b1;
          state_q  <= ST_OUT;
        end

        ST_OUT: begin
          if (out_load) begin
            out_data_q  <= {{OUT_PAD_W{1'b0}}, COUNT_OUT_W'(count_q),
                            res_fv_q, res_fk_q, res_ok_q};
            state_q     <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // output fields for the checks below
  logic               out_ok;
  logic [KEY_W-1:0]   out_fk;
  logic [VALUE_W-1:0] out_fv;
  logic               in_sweep;

  assign out_ok   = out_data_q[0];
  assign out_fk   = out_data_q[1 +: KEY_W];
  assign out_fv   = out_data_q[1 + KEY_W +: VALUE_W];
  assign in_sweep = (state_q == ST_FIND) || (state_q == ST_SHIFT) ||
                    (state_q == ST_RK_SWEEP);

  `KVT_ASSERT(a_count_range, count_q <= CW'(CAPACITY), "entry count above capacity")
  `KVT_ASSERT_NXT(a_busy_after_item, in_fire, !s_axis_tready_o, "ready after an item")
  `KVT_ASSERT_IMP(a_sweep_state, rd_vld_q, in_sweep, "sweep data outside a sweep")
  `KVT_ASSERT_IMP(a_fail_zero, out_valid_q && !out_ok, out_fk == '0 && out_fv == '0,
                  "failed result carries data")
  `KVT_ASSERT_IMP(a_count_step, count_q != $past(count_q),
                  count_q == $past(count_q) + CW'(1) || count_q + CW'(1) == $past(count_q),
                  "entry count jumped")

endmodule

`default_nettype wire
